@@ hw/rtl/merge_insertion_sorter_macros.svh @@
// Assertion macros for the merge insertion sorter.
// Each macro expects a clk and an active-low rst_n in the enclosing module.
`ifndef MERGE_INSERTION_SORTER_MACROS_SVH
`define MERGE_INSERTION_SORTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define MIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define MIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mis_pkg.sv @@
// Shared types and constants for the merge insertion sorter.
// No dependencies; used by mis_cell and merge_insertion_sorter.
package mis_pkg;

  localparam int MIS_VALUE_W   = 31;
  localparam int MIS_MAX_ITEMS = 64;

  // Input beat
  typedef struct packed {
    logic [MIS_VALUE_W-1:0] in_value;
    logic                   in_last;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [MIS_VALUE_W-1:0] out_value;
    logic                   out_last;
    logic                   overflow;
  } out_t;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic [MIS_VALUE_W-1:0] value;
    logic                   valid;
  } cell_bus_t;

  // Row-wide command to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast value
    logic shl;  // shift the row one place toward cell 0
  } cell_ctl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage

@@ hw/rtl/merge_insertion_sorter.sv @@
// Top level of the merge insertion sorter: a row of mis_cell plus fill/drain control.
// Depends on mis_pkg, mis_cell and merge_insertion_sorter_macros.svh.

// Collects a set of values, one per beat, and emits them in ascending order.
// While filling, the block takes one beat per cycle. Each beat is compared in
// parallel against every cell of a row of MAX_ITEMS cells and slotted in place
// in that same cycle. The beat with in_last starts the drain: busy rises and
// the row shifts toward cell 0 once per cycle, giving one result per cycle
// straight from cell 0. A set of n beats therefore stores and drains
// min(n, MAX_ITEMS) values. Busy falls in the cycle after the final result.
// Results carry a one-cycle strobe and cannot be stalled; the receiver must
// take every result as it comes. Values arriving with the row full are
// dropped and every result of that set shows overflow. No clearing pass is
// needed after reset.
module merge_insertion_sorter #(
  parameter int MAX_ITEMS = mis_pkg::MIS_MAX_ITEMS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mis_pkg::in_t  in_data,
  output logic          out_strobe,
  output mis_pkg::out_t out_data
);
  import mis_pkg::*;

  `include "merge_insertion_sorter_macros.svh"

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               flag_r, flag_nxt;
  logic               accept;
  logic               full;
  cell_ctl_t          ctl;

  cell_bus_t          q_bus     [MAX_ITEMS];
  logic               lt_flag   [MAX_ITEMS];
  cell_bus_t          left_bus  [MAX_ITEMS];
  logic               left_lt   [MAX_ITEMS];
  cell_bus_t          right_bus [MAX_ITEMS];

  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(MAX_ITEMS));

  // Drive the row command
  assign ctl.ins = accept && !full;
  assign ctl.shl = (state_r == ST_DRAIN);

  // Build the row of cells and their neighbor links
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_row
    if (i == 0) begin : g_head
      assign left_bus[i] = '{value: '0, valid: 1'b0};
      assign left_lt[i]  = 1'b0;
    end else begin : g_mid
      assign left_bus[i] = q_bus[i-1];
      assign left_lt[i]  = lt_flag[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_bus[i] = '{value: '0, valid: 1'b0};
    end else begin : g_link
      assign right_bus[i] = q_bus[i+1];
    end

    mis_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_value (in_data.in_value),
      .left      (left_bus[i]),
      .left_lt   (left_lt[i]),
      .right     (right_bus[i]),
      .q         (q_bus[i]),
      .lt        (lt_flag[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (accept && in_data.in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (count_r == CNT_W'(1)) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Count and drop flag: count holds stored values while filling, remaining while draining
  always_comb begin
    count_nxt = count_r;
    flag_nxt  = flag_r;
    case (state_r)
      ST_FILL: begin
        if (accept) begin
          if (full) flag_nxt = 1'b1;
          else      count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) flag_nxt = 1'b0;
      end
      default: begin
        count_nxt = '0;
        flag_nxt  = 1'b0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy               = 1'b0;
    out_strobe         = 1'b0;
    out_data.out_value = q_bus[0].value;
    out_data.out_last  = (count_r == CNT_W'(1));
    out_data.overflow  = flag_r;
    case (state_r)
      ST_FILL: begin
        busy       = 1'b0;
        out_strobe = 1'b0;
      end
      ST_DRAIN: begin
        busy       = 1'b1;
        out_strobe = 1'b1;
      end
      default: begin
        busy       = 1'b0;
        out_strobe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // Checks
  `MIS_ASSERT_NOW(a_strobe_holds_valid, out_strobe, q_bus[0].valid, "result from an empty cell")
  `MIS_ASSERT_NEXT(a_last_starts_drain, accept && in_data.in_last, out_strobe, "drain did not start")
  `MIS_ASSERT_NEXT(a_last_ends_drain, out_strobe && out_data.out_last, !busy, "busy after final result")
  `MIS_ASSERT_NEXT(a_ascending, out_strobe && !out_data.out_last, out_strobe && (out_data.out_value >= $past(out_data.out_value)), "results out of order")

endmodule

@@ hw/rtl/mis_cell.sv @@
// One cell of the sorting row: holds one value and its valid bit.
// Depends on mis_pkg for the bus and command types.
module mis_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mis_pkg::cell_ctl_t       ctl,
  input  logic [mis_pkg::MIS_VALUE_W-1:0] ins_value,
  input  mis_pkg::cell_bus_t       left,
  input  logic                     left_lt,
  input  mis_pkg::cell_bus_t       right,
  output mis_pkg::cell_bus_t       q,
  output logic                     lt
);
  import mis_pkg::*;

  logic [MIS_VALUE_W-1:0] value_r, value_nxt;
  logic                   valid_r, valid_nxt;

  // An empty cell counts as larger than anything
  assign lt = !valid_r || (ins_value < value_r);

  // Keep, take the broadcast value, take the left neighbor, or shift from the right
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.shl) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end else if (ctl.ins && lt) begin
      if (left_lt) begin
        value_nxt = left.value;
        valid_nxt = left.valid;
      end else begin
        value_nxt = ins_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign q.value = value_r;
  assign q.valid = valid_r;

endmodule
